// ===== rtl/ebjd_pkg.sv =====
// Shared types, register indexes and reset values for the EEG blink and jaw pulse detector.
// No dependencies; imported by every module of the block.
package ebjd_pkg;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LEVEL_W = 15;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned JCNT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HIGH_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LOW_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_WINDOW_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JAW_LEVEL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JAW_PHASE_COUNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_JAW_WINDOW_MS    = 3'd6;

    localparam logic [LEVEL_W-1:0] BLINK_LEVEL_RST      = 15'd800;
    localparam logic [BCNT_W-1:0]  BLINK_HIGH_COUNT_RST = 4'd8;
    localparam logic [BCNT_W-1:0]  BLINK_LOW_COUNT_RST  = 4'd12;
    localparam logic [WIN_W-1:0]   BLINK_WINDOW_MS_RST  = 16'd400;
    localparam logic [LEVEL_W-1:0] JAW_LEVEL_RST        = 15'd800;
    localparam logic [JCNT_W-1:0]  JAW_PHASE_COUNT_RST  = 2'd2;
    localparam logic [WIN_W-1:0]   JAW_WINDOW_MS_RST    = 16'd200;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_HIGH = 2'd1,
        B_LOW  = 2'd2
    } t_blink_phase;

    typedef enum logic [2:0] {
        J_IDLE = 3'd0,
        J_H1   = 3'd1,
        J_L1   = 3'd2,
        J_H2   = 3'd3,
        J_L2   = 3'd4
    } t_jaw_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [BCNT_W-1:0]  high_count;
        logic [BCNT_W-1:0]  low_count;
        logic [WIN_W-1:0]   window_ms;
    } t_blink_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [JCNT_W-1:0]  phase_count;
        logic [WIN_W-1:0]   window_ms;
    } t_jaw_cfg;

    typedef struct packed {
        logic event_hit;
        logic noise;
    } t_det_res;

endpackage

// ===== rtl/eeg_blink_and_jaw_pulse_detector_top.sv =====
// Top level of the EEG blink and jaw pulse detector: ports, registers, input and result stages.
// Depends on ebjd_pkg, ebjd_blink and ebjd_jaw.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_raw_sample, i_now_ms | sample in
//   out     | o_out_valid, i_out_ready, o_blink_event, o_drive_run,
//           | o_blink_noise, o_jaw_event, o_jaw_noise   | result out
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata          | register write
//
// One sample per cycle sustained while the output is not stalled; a sample passes through the
// input register, then the detectors' single pass into the result register.
// Synchronous active-low reset clears both detectors, drive bit and valid flags; reloads config.
// A stalled result holds in the result register while one more sample waits in the input
// register; ready drops only when both are full and the output is stalled.
module eeg_blink_and_jaw_pulse_detector_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [ebjd_pkg::RAW_W-1:0]     i_raw_sample,
    input  logic [ebjd_pkg::TIME_W-1:0]           i_now_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_blink_event,
    output logic                                  o_drive_run,
    output logic                                  o_blink_noise,
    output logic                                  o_jaw_event,
    output logic                                  o_jaw_noise,
    input  logic                                  i_cfg_we,
    input  logic [ebjd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ebjd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import ebjd_pkg::*;

    t_blink_cfg              r_blink_cfg;
    t_jaw_cfg                r_jaw_cfg;

    logic                    r_s_valid;
    logic signed [RAW_W-1:0] r_s_raw;
    logic [TIME_W-1:0]       r_s_now;

    logic                    r_o_valid;
    logic                    r_o_blink_event, r_o_drive_run, r_o_blink_noise;
    logic                    r_o_jaw_event, r_o_jaw_noise;

    logic                    w_advance;
    t_det_res                w_blink_res, w_jaw_res;
    logic                    w_drive;

    assign w_advance  = r_s_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_cfg.level      <= BLINK_LEVEL_RST;
            r_blink_cfg.high_count <= BLINK_HIGH_COUNT_RST;
            r_blink_cfg.low_count  <= BLINK_LOW_COUNT_RST;
            r_blink_cfg.window_ms  <= BLINK_WINDOW_MS_RST;
            r_jaw_cfg.level        <= JAW_LEVEL_RST;
            r_jaw_cfg.phase_count  <= JAW_PHASE_COUNT_RST;
            r_jaw_cfg.window_ms    <= JAW_WINDOW_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLINK_LEVEL:      r_blink_cfg.level      <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_BLINK_HIGH_COUNT: r_blink_cfg.high_count <= i_cfg_wdata[BCNT_W-1:0];
                CFG_BLINK_LOW_COUNT:  r_blink_cfg.low_count  <= i_cfg_wdata[BCNT_W-1:0];
                CFG_BLINK_WINDOW_MS:  r_blink_cfg.window_ms  <= i_cfg_wdata[WIN_W-1:0];
                CFG_JAW_LEVEL:        r_jaw_cfg.level        <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_JAW_PHASE_COUNT:  r_jaw_cfg.phase_count  <= i_cfg_wdata[JCNT_W-1:0];
                CFG_JAW_WINDOW_MS:    r_jaw_cfg.window_ms    <= i_cfg_wdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s_raw <= i_raw_sample;
            r_s_now <= i_now_ms;
        end
    end

    ebjd_blink u_blink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_raw   (r_s_raw),
        .i_now   (r_s_now),
        .i_cfg   (r_blink_cfg),
        .o_res   (w_blink_res),
        .o_drive (w_drive)
    );

    ebjd_jaw u_jaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_raw   (r_s_raw),
        .i_now   (r_s_now),
        .i_cfg   (r_jaw_cfg),
        .o_res   (w_jaw_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_advance) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_o_blink_event <= w_blink_res.event_hit;
            r_o_drive_run   <= w_drive;
            r_o_blink_noise <= w_blink_res.noise;
            r_o_jaw_event   <= w_jaw_res.event_hit;
            r_o_jaw_noise   <= w_jaw_res.noise;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_blink_event = r_o_blink_event;
    assign o_drive_run   = r_o_drive_run;
    assign o_blink_noise = r_o_blink_noise;
    assign o_jaw_event   = r_o_jaw_event;
    assign o_jaw_noise   = r_o_jaw_noise;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s_valid && r_o_valid && !i_out_ready))
        else $error("input stalled with room in the stages");

    a_blink_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_blink_event && r_o_blink_noise))
        else $error("blink event and blink noise on one result");

    a_jaw_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_jaw_event && r_o_jaw_noise))
        else $error("jaw event and jaw noise on one result");

endmodule

// ===== rtl/ebjd_blink.sv =====
// Blink detector: high run then low run within a window; toggles the run/stop drive bit.
// Depends on ebjd_pkg.
module ebjd_blink (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic signed [ebjd_pkg::RAW_W-1:0]   i_raw,
    input  logic [ebjd_pkg::TIME_W-1:0]         i_now,
    input  ebjd_pkg::t_blink_cfg                i_cfg,
    output ebjd_pkg::t_det_res                  o_res,
    output logic                                o_drive
);
    import ebjd_pkg::*;

    t_blink_phase        r_phase, n_phase;
    logic [BCNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]   r_start, n_start;
    logic                r_drive_on, n_drive_on;

    logic signed [RAW_W:0] w_raw_x;
    logic signed [RAW_W:0] w_lev;
    logic                  w_hi, w_lo;
    logic [TIME_W-1:0]     w_elapsed;
    logic [BCNT_W-1:0]     w_inc;
    logic                  w_in_time;
    logic                  w_event, w_noise;

    assign w_raw_x   = {i_raw[RAW_W-1], i_raw};
    assign w_lev     = {2'b00, i_cfg.level};
    assign w_hi      = w_raw_x > w_lev;
    assign w_lo      = w_raw_x < -w_lev;
    assign w_elapsed = i_now - r_start;
    assign w_in_time = w_elapsed < {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ms};
    assign w_inc     = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_start    = r_start;
        n_drive_on = r_drive_on;
        w_event    = 1'b0;
        w_noise    = 1'b0;
        unique case (r_phase)
            B_IDLE: begin
                if (w_hi) begin
                    n_phase = B_HIGH;
                    n_start = i_now;
                    n_count = w_inc;
                end
            end
            B_HIGH: begin
                if (w_hi) begin
                    n_count = w_inc;
                    if (w_inc >= i_cfg.high_count) begin
                        n_phase = B_LOW;
                        n_count = '0;
                    end
                end else if (w_lo) begin
                    n_phase = B_IDLE;
                    n_count = '0;
                    n_start = '0;
                    w_noise = 1'b1;
                end
            end
            B_LOW: begin
                if (w_lo) begin
                    n_count = w_inc;
                    if (w_inc >= i_cfg.low_count && w_in_time) begin
                        n_phase    = B_IDLE;
                        n_count    = '0;
                        n_start    = '0;
                        w_event    = 1'b1;
                        n_drive_on = ~r_drive_on;
                    end
                end else if (w_hi && r_count != '0) begin
                    n_phase = B_IDLE;
                    n_count = '0;
                    n_start = '0;
                    w_noise = 1'b1;
                end
            end
            default: begin
                n_phase = B_IDLE;
                n_count = '0;
                n_start = '0;
            end
        endcase
        // timeout: start only changes on entry from idle, which this check skips
        if (r_phase != B_IDLE && n_phase != B_IDLE &&
            w_elapsed > {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ms}) begin
            n_phase = B_IDLE;
            n_count = '0;
            n_start = '0;
            w_noise = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= B_IDLE;
            r_count    <= '0;
            r_start    <= '0;
            r_drive_on <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_start    <= n_start;
            r_drive_on <= n_drive_on;
        end
    end

    assign o_res.event_hit = w_event;
    assign o_res.noise     = w_noise;
    assign o_drive         = n_drive_on;

    a_drive_follows_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> (r_drive_on != $past(r_drive_on)) == $past(w_event))
        else $error("drive bit did not toggle exactly on a blink");

    a_idle_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == B_IDLE |-> (r_count == '0 && r_start == '0))
        else $error("blink idle with stale count or start");

endmodule

// ===== rtl/ebjd_jaw.sv =====
// Jaw pulse detector: high, low, high, low phases of a configured length within a window.
// Depends on ebjd_pkg.
module ebjd_jaw (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic signed [ebjd_pkg::RAW_W-1:0]   i_raw,
    input  logic [ebjd_pkg::TIME_W-1:0]         i_now,
    input  ebjd_pkg::t_jaw_cfg                  i_cfg,
    output ebjd_pkg::t_det_res                  o_res
);
    import ebjd_pkg::*;

    t_jaw_phase          r_phase, n_phase;
    logic [JCNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]   r_start, n_start;

    logic signed [RAW_W:0] w_raw_x;
    logic signed [RAW_W:0] w_lev;
    logic                  w_hi, w_lo;
    logic [TIME_W-1:0]     w_elapsed;
    logic [JCNT_W-1:0]     w_inc;
    logic                  w_done;
    logic                  w_event, w_noise;

    assign w_raw_x   = {i_raw[RAW_W-1], i_raw};
    assign w_lev     = {2'b00, i_cfg.level};
    assign w_hi      = w_raw_x > w_lev;
    assign w_lo      = w_raw_x < -w_lev;
    assign w_elapsed = i_now - r_start;
    assign w_inc     = (r_count == '1) ? r_count : r_count + 1'b1;
    assign w_done    = w_inc >= i_cfg.phase_count;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_start = r_start;
        w_event = 1'b0;
        w_noise = 1'b0;
        unique case (r_phase)
            J_IDLE: begin
                if (w_hi) begin
                    n_phase = J_H1;
                    n_start = i_now;
                    n_count = w_inc;
                end
            end
            J_H1, J_H2: begin
                if (w_hi) begin
                    n_count = w_inc;
                    if (w_done) begin
                        n_phase = (r_phase == J_H1) ? J_L1 : J_L2;
                        n_count = '0;
                    end
                end
            end
            J_L1: begin
                if (w_lo) begin
                    n_count = w_inc;
                    if (w_done) begin
                        n_phase = J_H2;
                        n_count = '0;
                    end
                end
            end
            J_L2: begin
                if (w_lo) begin
                    n_count = w_inc;
                    if (w_done &&
                        w_elapsed < {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ms}) begin
                        n_phase = J_IDLE;
                        n_count = '0;
                        n_start = '0;
                        w_event = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = J_IDLE;
                n_count = '0;
                n_start = '0;
            end
        endcase
        if (r_phase != J_IDLE && n_phase != J_IDLE &&
            w_elapsed > {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ms}) begin
            n_phase = J_IDLE;
            n_count = '0;
            n_start = '0;
            w_noise = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= J_IDLE;
            r_count <= '0;
            r_start <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_start <= n_start;
        end
    end

    assign o_res.event_hit = w_event;
    assign o_res.noise     = w_noise;

    a_idle_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == J_IDLE |-> (r_count == '0 && r_start == '0))
        else $error("jaw idle with stale count or start");

endmodule
